### rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared constants, codes, command/status types and helpers for the
// two-ball spring contact stepper.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  localparam logic [63:0] ONE_Q      = 64'd1 << FRAC_BITS;
  localparam logic [63:0] TWO32      = 64'h1_0000_0000;
  localparam logic [63:0] FIVE_ONE_Q = ONE_Q * 64'd5;

  localparam logic signed [31:0] WMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WMIN = 32'sh8000_0000;

  // item kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_MASS_A      = 3'd0;
  localparam logic [2:0] CFG_MASS_B      = 3'd1;
  localparam logic [2:0] CFG_STIFF_A     = 3'd2;
  localparam logic [2:0] CFG_STIFF_B     = 3'd3;
  localparam logic [2:0] CFG_RADIUS_A    = 3'd4;
  localparam logic [2:0] CFG_RADIUS_B    = 3'd5;
  localparam logic [2:0] CFG_FRICTION    = 3'd6;
  localparam logic [2:0] CFG_TIME_STEP   = 3'd7;

  // micro-op sequence of one step
  localparam logic [4:0] U_DX2    = 5'd0;
  localparam logic [4:0] U_DY2    = 5'd1;
  localparam logic [4:0] U_R2     = 5'd2;
  localparam logic [4:0] U_SQRT   = 5'd3;
  localparam logic [4:0] U_KEFF   = 5'd4;
  localparam logic [4:0] U_FORCE  = 5'd5;
  localparam logic [4:0] U_TQ1    = 5'd6;
  localparam logic [4:0] U_TQ2    = 5'd7;
  localparam logic [4:0] U_BALL_A = 5'd8;
  localparam logic [4:0] U_BALL_B = 5'd17;
  localparam logic [4:0] U_POS    = 5'd26;
  localparam logic [4:0] U_LAST   = 5'd29;

  // per-ball sub-ops
  localparam logic [3:0] B_ACC = 4'd0;
  localparam logic [3:0] B_DV  = 4'd1;
  localparam logic [3:0] B_VX  = 4'd2;
  localparam logic [3:0] B_VY  = 4'd3;
  localparam logic [3:0] B_SQ1 = 4'd4;
  localparam logic [3:0] B_SQ2 = 4'd5;
  localparam logic [3:0] B_INR = 4'd6;
  localparam logic [3:0] B_ALP = 4'd7;
  localparam logic [3:0] B_DW  = 4'd8;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic       flags;
    logic       issue;
    logic       wb;
    logic       step_end;
    logic       out_load;
    logic [4:0] uop;
  } tsc_cmd_t;

  typedef struct packed {
    logic skip;
    logic done;
  } tsc_stat_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] w,
                                                 input logic neg,
                                                 input logic [63:0] mag);
    logic [31:0]        room;
    logic signed [31:0] r;
    room = neg ? {~w[31], w[30:0]} : {w[31], ~w[30:0]};
    if (mag >= {32'd0, room}) begin
      r = neg ? WMIN : WMAX;
    end else begin
      r = neg ? w - $signed(mag[31:0]) : w + $signed(mag[31:0]);
    end
    return r;
  endfunction

endpackage

### rtl/tsc_muldiv.sv
// ----------------------------------------------------------------------------
// tsc_muldiv
// Shared floor(a*b/c) unit: 64x64 product from four 32x32 partial products,
// then a shift for a divisor of one or a Q16.16 or Q0.32 scale, byte-wise
// division for the five-times-one scale, otherwise restoring division one
// quotient bit a cycle. All ones on overflow or a zero divisor.
// ----------------------------------------------------------------------------
module tsc_muldiv import tsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] c,
  output logic        done,
  output logic [63:0] q
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MUL  = 3'd1;
  localparam logic [2:0] PH_CHK  = 3'd2;
  localparam logic [2:0] PH_DIV  = 3'd3;
  localparam logic [2:0] PH_DIV5 = 3'd4;

  logic [2:0]   phase;
  logic [5:0]   cnt;
  logic [63:0]  a_r, b_r, c_r;
  logic [63:0]  hi, lo;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] prod_next;
  logic [63:0]  sh;
  logic         ge;
  logic [2:0]   rem5;
  logic [10:0]  x5;
  logic [21:0]  x5_prod;
  logic [7:0]   q5;
  logic [10:0]  r5;

  always_comb begin
    pa = cnt[1] ? a_r[63:32] : a_r[31:0];
    pb = cnt[0] ? b_r[63:32] : b_r[31:0];
    pp = pa * pb;
    case (cnt[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    prod_next = {hi, lo} + pp_sh;
    sh = {hi[62:0], lo[63]};
    ge = hi[63] || (sh >= c_r);
    // one quotient byte by 5: reciprocal 3277/2^14 is exact below 1280
    x5      = {rem5, lo[63:56]};
    x5_prod = 22'(x5) * 22'd3277;
    q5      = x5_prod[21:14];
    r5      = x5 - 11'(q5) * 11'd5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            a_r   <= a;
            b_r   <= b;
            c_r   <= c;
            hi    <= '0;
            lo    <= '0;
            cnt   <= '0;
            phase <= PH_MUL;
          end
        end
        PH_MUL: begin
          {hi, lo} <= prod_next;
          cnt      <= cnt + 6'd1;
          if (cnt[1:0] == 2'd3) begin
            phase <= PH_CHK;
          end
        end
        PH_CHK: begin
          cnt <= '0;
          if (c_r == 64'd0 || hi >= c_r) begin
            lo    <= '1;
            done  <= 1'b1;
            phase <= PH_IDLE;
          end else if (c_r == 64'd1) begin
            done  <= 1'b1;
            phase <= PH_IDLE;
          end else if (c_r == ONE_Q) begin
            lo    <= {hi[FRAC_BITS-1:0], lo[63:FRAC_BITS]};
            done  <= 1'b1;
            phase <= PH_IDLE;
          end else if (c_r == TWO32) begin
            lo    <= {hi[31:0], lo[63:32]};
            done  <= 1'b1;
            phase <= PH_IDLE;
          end else if (c_r == FIVE_ONE_Q) begin
            lo    <= {hi[FRAC_BITS-1:0], lo[63:FRAC_BITS]};
            rem5  <= hi[FRAC_BITS+2:FRAC_BITS];
            phase <= PH_DIV5;
          end else begin
            phase <= PH_DIV;
          end
        end
        PH_DIV: begin
          hi  <= ge ? sh - c_r : sh;
          lo  <= {lo[62:0], ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            done  <= 1'b1;
            phase <= PH_IDLE;
          end
        end
        PH_DIV5: begin
          lo   <= {lo[55:0], q5};
          rem5 <= r5[2:0];
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd7) begin
            done  <= 1'b1;
            phase <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  assign q = lo;

endmodule

### rtl/tsc_sqrt.sv
// ----------------------------------------------------------------------------
// tsc_sqrt
// Integer square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module tsc_sqrt import tsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] v,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [63:0] v_r, res, bitv, trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v_r  <= v;
        res  <= '0;
        bitv <= 64'd1 << 62;
        busy <= 1'b1;
      end else if (busy) begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[31:0];

endmodule

### rtl/tsc_dp.sv
// ----------------------------------------------------------------------------
// tsc_dp
// Datapath: configuration and ball state registers, operand selection for
// the shared multiply-divide and square-root units, saturating writeback
// and the result register.
// ----------------------------------------------------------------------------
module tsc_dp import tsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data,
  input  logic [319:0] load_data,
  input  tsc_cmd_t     cmd,
  output tsc_stat_t    stat,
  output logic [359:0] out_data
);

  logic [30:0] mass_a, mass_b, stiff_a, stiff_b, radius_a, radius_b;
  logic [31:0] friction, time_step;

  logic signed [31:0] pos [4];
  logic signed [31:0] vel [4];
  logic signed [31:0] spin [2];
  logic [31:0]        step_cnt;

  logic signed [32:0] dx, dy;
  logic [32:0]        ux, uy;
  logic               near, contact, a_faster;
  logic [63:0]        dx2, dy2, r2;
  logic [31:0]        d, cov;
  logic [63:0]        keff, push, tq, torque;
  logic [63:0]        acc, dv, sq1, sq, inertia, alpha;

  logic [31:0] rr, ksum;
  logic        contact_w;
  logic        ball_b, in_ball, in_pos;
  logic [4:0]  sub_full;
  logic [3:0]  sub;
  logic [1:0]  pidx, vsel;
  logic [30:0] m_eff, rad;
  logic [31:0] s_abs;
  logic signed [31:0] vel_cur;
  logic [31:0] vel_mag;
  logic        negx, negy, neg_tq, d_zero;
  logic [63:0] op_a, op_b, op_c;
  logic        md_start, md_done, sq_start, sq_done;
  logic [63:0] md_q;
  logic [31:0] sq_root;
  logic [64:0] sq_sum;

  always_comb begin
    rr        = {1'b0, radius_a} + {1'b0, radius_b};
    ksum      = {1'b0, stiff_a} + {1'b0, stiff_b};
    near      = (ux < {1'b0, rr}) && (uy < {1'b0, rr});
    contact_w = near && (dx2 < r2 - dy2);
    ball_b    = (cmd.uop >= U_BALL_B) && (cmd.uop < U_POS);
    in_ball   = (cmd.uop >= U_BALL_A) && (cmd.uop < U_POS);
    in_pos    = cmd.uop >= U_POS;
    sub_full  = cmd.uop - (ball_b ? U_BALL_B : U_BALL_A);
    sub       = sub_full[3:0];
    pidx      = 2'(cmd.uop - U_POS);
    vsel      = in_pos ? pidx : {ball_b, sub == B_VY};
    vel_cur   = vel[vsel];
    vel_mag   = vel_cur[31] ? 32'(-vel_cur) : vel_cur;
    m_eff     = ((ball_b ? mass_b : mass_a) == 31'd0) ? 31'd1 : (ball_b ? mass_b : mass_a);
    rad       = ball_b ? radius_b : radius_a;
    s_abs     = ({1'b0, rad} > cov) ? {1'b0, rad} - cov : cov - {1'b0, rad};
    negx      = ball_b ? dx[32] : (!dx[32] && dx != 33'sd0);
    negy      = ball_b ? dy[32] : (!dy[32] && dy != 33'sd0);
    neg_tq    = ball_b ? !a_faster : a_faster;
    d_zero    = d == 32'd0;
    sq_sum    = {1'b0, sq1} + {1'b0, md_q};
  end

  // operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_c = 64'd1;
    if (in_pos) begin
      op_a = {32'd0, vel_mag};
      op_b = {32'd0, time_step};
      op_c = TWO32;
    end else if (in_ball) begin
      case (sub)
        B_ACC: begin op_a = push; op_b = ONE_Q; op_c = {33'd0, m_eff}; end
        B_DV:  begin op_a = acc; op_b = {32'd0, time_step}; op_c = TWO32; end
        B_VX: begin
          op_a = dv;
          op_b = d_zero ? 64'd1 : {31'd0, ux};
          op_c = d_zero ? 64'd1 : {32'd0, d};
        end
        B_VY:  begin op_a = dv; op_b = {31'd0, uy}; op_c = {32'd0, d}; end
        B_SQ1: begin op_a = {32'd0, s_abs}; op_b = {32'd0, s_abs}; op_c = ONE_Q; end
        B_SQ2: begin op_a = {33'd0, rad}; op_b = {33'd0, rad}; op_c = ONE_Q; end
        B_INR: begin op_a = {33'd0, m_eff}; op_b = sq; op_c = FIVE_ONE_Q; end
        B_ALP: begin op_a = torque; op_b = ONE_Q; op_c = inertia; end
        B_DW:  begin op_a = alpha; op_b = {32'd0, time_step}; op_c = TWO32; end
        default: ;
      endcase
    end else begin
      case (cmd.uop)
        U_DX2:   begin op_a = {31'd0, ux}; op_b = {31'd0, ux}; end
        U_DY2:   begin op_a = {31'd0, uy}; op_b = {31'd0, uy}; end
        U_R2:    begin op_a = {32'd0, rr}; op_b = {32'd0, rr}; end
        U_KEFF:  begin op_a = {33'd0, stiff_a}; op_b = {33'd0, stiff_b}; op_c = {32'd0, ksum}; end
        U_FORCE: begin op_a = keff; op_b = {32'd0, cov}; op_c = ONE_Q; end
        U_TQ1:   begin op_a = push; op_b = {32'd0, friction}; op_c = TWO32; end
        U_TQ2:   begin op_a = tq; op_b = {32'd0, cov}; op_c = ONE_Q; end
        default: ;
      endcase
    end
  end

  // skip decision
  always_comb begin
    stat.done = md_done || sq_done;
    if (cmd.uop <= U_R2) begin
      stat.skip = !near;
    end else if (cmd.uop == U_SQRT) begin
      stat.skip = !contact_w;
    end else if (in_pos) begin
      stat.skip = 1'b0;
    end else begin
      stat.skip = !contact || (in_ball && sub == B_VY && d_zero);
    end
  end

  assign md_start  = cmd.issue && cmd.uop != U_SQRT;
  assign sq_start  = cmd.issue && cmd.uop == U_SQRT;

  tsc_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (op_a),
    .b     (op_b),
    .c     (op_c),
    .done  (md_done),
    .q     (md_q)
  );

  tsc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .v     (dx2 + dy2),
    .done  (sq_done),
    .root  (sq_root)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mass_a    <= 31'd65536;
      mass_b    <= 31'd65536;
      stiff_a   <= 31'd65536;
      stiff_b   <= 31'd65536;
      radius_a  <= 31'd65536;
      radius_b  <= 31'd65536;
      friction  <= 32'd275986009;
      time_step <= 32'd429497;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MASS_A:    mass_a    <= cfg_data[30:0];
        CFG_MASS_B:    mass_b    <= cfg_data[30:0];
        CFG_STIFF_A:   stiff_a   <= cfg_data[30:0];
        CFG_STIFF_B:   stiff_b   <= cfg_data[30:0];
        CFG_RADIUS_A:  radius_a  <= cfg_data[30:0];
        CFG_RADIUS_B:  radius_b  <= cfg_data[30:0];
        CFG_FRICTION:  friction  <= cfg_data;
        CFG_TIME_STEP: time_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // ball state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
      spin[0]  <= '0;
      spin[1]  <= '0;
      step_cnt <= '0;
      contact  <= 1'b0;
    end else if (cmd.load) begin
      for (int i = 0; i < 4; i++) begin
        pos[i] <= load_data[32*i +: 32];
        vel[i] <= load_data[128 + 32*i +: 32];
      end
      spin[0]  <= load_data[287:256];
      spin[1]  <= load_data[319:288];
      step_cnt <= '0;
      contact  <= 1'b0;
    end else begin
      if (cmd.prep) begin
        contact <= 1'b0;
      end
      if (cmd.flags) begin
        contact <= contact_w;
      end
      if (cmd.step_end) begin
        step_cnt <= step_cnt + 32'd1;
      end
      if (cmd.wb) begin
        if (in_pos) begin
          pos[pidx] <= sat_add(pos[pidx], vel_cur[31], md_q);
        end else if (in_ball) begin
          case (sub)
            B_VX:    vel[vsel] <= sat_add(vel_cur, !d_zero && negx, md_q);
            B_VY:    vel[vsel] <= sat_add(vel_cur, negy, md_q);
            B_DW:    spin[ball_b] <= sat_add(spin[ball_b], neg_tq, md_q);
            default: ;
          endcase
        end
      end
    end
  end

  // step temporaries
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dx   <= 33'(pos[2]) - 33'(pos[0]);
      dy   <= 33'(pos[3]) - 33'(pos[1]);
      ux   <= (pos[2] > pos[0]) ? 33'(33'(pos[2]) - 33'(pos[0]))
                                : 33'(33'(pos[0]) - 33'(pos[2]));
      uy   <= (pos[3] > pos[1]) ? 33'(33'(pos[3]) - 33'(pos[1]))
                                : 33'(33'(pos[1]) - 33'(pos[3]));
    end
    if (cmd.flags) begin
      a_faster <= spin[0] > spin[1];
    end
    if (cmd.wb) begin
      if (in_ball) begin
        case (sub)
          B_ACC:   acc     <= md_q;
          B_DV:    dv      <= md_q;
          B_SQ1:   sq1     <= md_q;
          B_SQ2:   sq      <= sq_sum[64] ? '1 : sq_sum[63:0];
          B_INR:   inertia <= (md_q == 64'd0) ? 64'd1 : md_q;
          B_ALP:   alpha   <= md_q;
          default: ;
        endcase
      end else if (!in_pos) begin
        case (cmd.uop)
          U_DX2:   dx2    <= md_q;
          U_DY2:   dy2    <= md_q;
          U_R2:    r2     <= md_q;
          U_SQRT: begin
            d   <= sq_root;
            cov <= rr - sq_root;
          end
          U_KEFF:  keff   <= (ksum == 32'd0) ? 64'd0 : md_q;
          U_FORCE: push   <= md_q;
          U_TQ1:   tq     <= md_q;
          U_TQ2:   torque <= md_q;
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {7'd0, contact, spin[1], spin[0], vel[3], vel[2], vel[1], vel[0],
                   pos[3], pos[2], pos[1], pos[0], step_cnt};
    end
  end

endmodule

### rtl/tsc_ctrl.sv
// ----------------------------------------------------------------------------
// tsc_ctrl
// Controller: input handshake, micro-op sequencing of one step, result
// handoff to the output register.
// ----------------------------------------------------------------------------
module tsc_ctrl import tsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic      op,
  output logic      m_tvalid,
  input  logic      m_tready,
  output tsc_cmd_t  cmd,
  input  tsc_stat_t stat
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state;
  logic [4:0] uop;

  assign s_tready = state == ST_IDLE;

  always_comb begin
    cmd     = '0;
    cmd.uop = uop;
    case (state)
      ST_IDLE: cmd.load = s_tvalid && op == OP_LOAD;
      ST_PREP: cmd.prep = 1'b1;
      ST_RUN: begin
        cmd.flags = uop == U_SQRT;
        cmd.issue = !stat.skip;
      end
      ST_WAIT: begin
        cmd.wb       = stat.done;
        cmd.step_end = stat.done && uop == U_LAST;
      end
      ST_OUT:  cmd.out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      uop      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= (op == OP_STEP) ? ST_PREP : ST_OUT;
          end
        end
        ST_PREP: begin
          uop   <= U_DX2;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (stat.skip) begin
            uop <= uop + 5'd1;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (stat.done) begin
            if (uop == U_LAST) begin
              state <= ST_OUT;
            end else begin
              uop   <= uop + 5'd1;
              state <= ST_RUN;
            end
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_WAIT)
    else $error("engine done outside wait");

  a_issue_waits: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |=> state == ST_WAIT)
    else $error("issue did not enter wait");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && stat.done && uop == U_LAST) |=> state == ST_OUT)
    else $error("last op did not finish the step");

endmodule

### rtl/two_sphere_contact_step_core.sv
// ----------------------------------------------------------------------------
// two_sphere_contact_step_core
// Two 2D balls with spring contact, stepped by semi-implicit Euler in
// Q16.16 fixed point with saturation.
// ----------------------------------------------------------------------------
// A load transfer (tuser 0) sets the state and returns it through the result
// register. A step transfer (tuser 1) runs a sequence of floor(a*b/c)
// operations on one shared multiply-divide unit: a product of four partial
// products, then a shift when the divisor is one or a Q16.16 or Q0.32 scale,
// byte-wise division for the inertia scale of five, else one quotient bit at
// a time. Without near approach only the position updates run, with it also
// the distance squares, and with contact the rest, including an integer
// square root on its own unit. One transfer is worked on at a time; the next
// can be accepted while a result waits on the output.
module two_sphere_contact_step_core import tsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // load_pos_ax, load_pos_ay, load_pos_bx, load_pos_by, load_vel_ax,
  // load_vel_ay, load_vel_bx, load_vel_by, load_spin_a, load_spin_b
  input  logic [319:0] s_tdata,
  // operation
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // step_number, pos_ax, pos_ay, pos_bx, pos_by, vel_ax, vel_ay, vel_bx,
  // vel_by, spin_a, spin_b, in_contact, zero fill
  output logic [359:0] m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  tsc_cmd_t  cmd;
  tsc_stat_t stat;

  tsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tsc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .load_data (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_tdata)
  );

endmodule
